>>> design/ppa_pkg.sv
// Shared types, widths and codes for the physical page allocator.
// Used by ppa_clip and the top level; depends on nothing.
`timescale 1ns / 1ps
package ppa_pkg;

	localparam int PAGE_BYTES   = 4096;
	localparam int STACK_DEPTH  = 1024;
	localparam int REGION_DEPTH = 1024;

	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int ADDR_W     = 48;
	localparam int LEN_W      = 49;
	localparam int CNT_W      = 49;
	localparam int SUM_W      = LEN_W + 1;
	localparam int PN_W       = LEN_W - PAGE_SHIFT;
	localparam int SPN_W      = ADDR_W - PAGE_SHIFT;
	localparam int STACK_AW   = $clog2(STACK_DEPTH);
	localparam int STACK_CW   = STACK_AW + 1;
	localparam int RGN_AW     = $clog2(REGION_DEPTH);
	localparam int RGN_CW     = RGN_AW + 1;

	typedef logic [PN_W-1:0] pn_t;

	typedef struct packed {
		pn_t next_pn;
		pn_t limit_pn;
	} region_t;

	typedef struct packed {
		logic             empty;
		pn_t              start_pn;
		pn_t              stop_pn;
		logic [LEN_W-1:0] bytes;
	} clip_t;

	typedef enum logic [1:0] {
		FUNC_ADD   = 2'd0,
		FUNC_ALLOC = 2'd1,
		FUNC_FREE  = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_OOM        = 3'd1,
		ST_STACK_FULL = 3'd2,
		ST_EMPTY      = 3'd3,
		ST_TABLE_FULL = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CFG_LOW_FLOOR      = 2'd0,
		CFG_RESERVED_START = 2'd1,
		CFG_RESERVED_END   = 2'd2,
		CFG_ADDRESS_LIMIT  = 2'd3
	} cfg_index_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD1,
		S_ADD2,
		S_ADD3,
		S_ADD4,
		S_ALLOC,
		S_POP_WB,
		S_RGN_WB,
		S_FREE,
		S_NOP
	} state_t;

endpackage

>>> design/ppa_ram.sv
// Simple dual-port synchronous RAM with one write and one registered read port.
// Generic; no package dependency.
`timescale 1ns / 1ps
module ppa_ram #(
	parameter int AW = 10,
	parameter int DW = 36
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> design/ppa_clip.sv
// Region clipping pipeline: aligns an added region to pages and clips it against
// the address limit, the low floor and the reserved window. Uses ppa_pkg.
`timescale 1ns / 1ps
module ppa_clip
	import ppa_pkg::*;
(
	input  logic              clk,
	input  logic [ADDR_W-1:0] low_floor,
	input  logic [ADDR_W-1:0] reserved_start,
	input  logic [ADDR_W-1:0] reserved_end,
	input  logic [LEN_W-1:0]  address_limit,
	input  logic [ADDR_W-1:0] region_base,
	input  logic [LEN_W-1:0]  region_length,
	output clip_t             clip
);

	localparam logic [LEN_W-1:0] PAGE_MASK = LEN_W'(PAGE_BYTES - 1);

	pn_t floor_pn_q, rs_pn_q, re_pn_q, lim_pn_q;
	pn_t start_s1, stop_s1, start_s2, stop_s2;
	pn_t start0, stop1, start1, start2, stop2;
	logic [SUM_W-1:0] sum;
	logic [SUM_W-PAGE_SHIFT-1:0] stop0;
	clip_t clip_s3;

	always_ff @(posedge clk) begin
		floor_pn_q <= PN_W'(({1'b0, low_floor} + PAGE_MASK) >> PAGE_SHIFT);
		rs_pn_q    <= PN_W'(reserved_start >> PAGE_SHIFT);
		re_pn_q    <= PN_W'(({1'b0, reserved_end} + PAGE_MASK) >> PAGE_SHIFT);
		lim_pn_q   <= address_limit[ADDR_W] ? (PN_W'(1) << SPN_W)
		                                    : PN_W'(address_limit >> PAGE_SHIFT);
	end

	always_comb begin
		start0 = PN_W'(({1'b0, region_base} + PAGE_MASK) >> PAGE_SHIFT);
		sum    = {2'b00, region_base} + {1'b0, region_length};
		stop0  = sum[SUM_W-1:PAGE_SHIFT];
		stop1  = (stop0 > {1'b0, lim_pn_q}) ? lim_pn_q : stop0[PN_W-1:0];
		start1 = (start0 < floor_pn_q) ? floor_pn_q : start0;
	end

	always_comb begin
		start2 = (start_s1 >= rs_pn_q && start_s1 < re_pn_q) ? re_pn_q : start_s1;
		stop2  = (stop_s1 >= rs_pn_q && stop_s1 < re_pn_q) ? rs_pn_q : stop_s1;
	end

	always_ff @(posedge clk) begin
		start_s1 <= start1;
		stop_s1  <= stop1;
		start_s2 <= start2;
		stop_s2  <= stop2;
		clip_s3.empty    <= start_s2 >= stop_s2;
		clip_s3.start_pn <= start_s2;
		clip_s3.stop_pn  <= stop_s2;
		clip_s3.bytes    <= {stop_s2 - start_s2, {PAGE_SHIFT{1'b0}}};
	end

	assign clip = clip_s3;

endmodule

>>> design/physical_page_allocator.sv
// Top level of the physical page allocator: control sequencer, counters,
// configuration registers, free-page stack RAM and region table RAM.
// Depends on ppa_pkg, ppa_ram and ppa_clip.
//
//  Channel  Handshake               Payload
//  input    start / busy            func, region_base, region_length, freed_page
//  result   done (one-cycle strobe) page_address, status, free_bytes
//  config   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// An item is taken when start is high and busy is low; done is registered. Free
// items push the stack, alloc items pop it or read the region table one region at a
// time until one has a page or the table ends, and add items pass the three-stage
// clip pipeline and write the table. The next item may start in the cycle of done.
// Reset clears the counters and loads the configuration reset values; the RAMs
// need no clearing. The receiver cannot stall; cfg_ready is always high.
`timescale 1ns / 1ps
module physical_page_allocator
	import ppa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        func,
	input  logic [ADDR_W-1:0] region_base,
	input  logic [LEN_W-1:0]  region_length,
	input  logic [ADDR_W-1:0] freed_page,
	output logic              done,
	output logic [ADDR_W-1:0] page_address,
	output logic [2:0]        status,
	output logic [CNT_W-1:0]  free_bytes,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [LEN_W-1:0]  cfg_data
);

	localparam logic [STACK_CW-1:0] STACK_FULL_CNT = STACK_CW'(STACK_DEPTH);
	localparam logic [RGN_CW-1:0]   RGN_FULL_CNT   = RGN_CW'(REGION_DEPTH);
	localparam logic [CNT_W-1:0]    PAGE_CNT       = CNT_W'(PAGE_BYTES);

	state_t state_q, state_d;

	logic [ADDR_W-1:0] low_floor_q, res_start_q, res_end_q;
	logic [LEN_W-1:0]  addr_limit_q;

	logic [ADDR_W-1:0] base_q, freed_q;
	logic [LEN_W-1:0]  length_q;

	logic [STACK_CW-1:0] stack_count_q;
	logic [RGN_CW-1:0]   region_count_q, cursor_q, cursor_inc;
	logic [CNT_W-1:0]    free_count_q, free_count_d;
	logic [CNT_W:0]      count_sum;

	logic              done_q;
	logic [ADDR_W-1:0] page_q;
	status_t           status_q;

	logic              fin;
	status_t           fin_status;
	logic [ADDR_W-1:0] fin_page;

	logic                stack_we;
	logic [STACK_AW-1:0] stack_waddr, stack_raddr;
	logic [SPN_W-1:0]    stack_wdata, stack_rdata;
	logic                rgn_we;
	logic [RGN_AW-1:0]   rgn_waddr, rgn_raddr;
	region_t             rgn_wdata, rgn_rdata;

	logic             cnt_add, cnt_sub;
	logic [LEN_W-1:0] add_bytes;
	logic             stack_inc, stack_dec, rgn_inc, cur_inc;
	logic             rgn_has_page;
	clip_t            clip;

	ppa_ram #(.AW(STACK_AW), .DW(SPN_W)) u_stack_ram (
		.clk   (clk),
		.we    (stack_we),
		.waddr (stack_waddr),
		.wdata (stack_wdata),
		.raddr (stack_raddr),
		.rdata (stack_rdata)
	);

	ppa_ram #(.AW(RGN_AW), .DW($bits(region_t))) u_region_ram (
		.clk   (clk),
		.we    (rgn_we),
		.waddr (rgn_waddr),
		.wdata (rgn_wdata),
		.raddr (rgn_raddr),
		.rdata (rgn_rdata)
	);

	ppa_clip u_clip (
		.clk            (clk),
		.low_floor      (low_floor_q),
		.reserved_start (res_start_q),
		.reserved_end   (res_end_q),
		.address_limit  (addr_limit_q),
		.region_base    (base_q),
		.region_length  (length_q),
		.clip           (clip)
	);

	assign busy         = (state_q != S_IDLE);
	assign cfg_ready    = 1'b1;
	assign done         = done_q;
	assign page_address = page_q;
	assign status       = status_q;
	assign free_bytes   = free_count_q;

	assign cursor_inc   = cursor_q + RGN_CW'(1);
	assign rgn_has_page = rgn_rdata.next_pn < rgn_rdata.limit_pn;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (func)
						FUNC_ADD:   state_d = S_ADD1;
						FUNC_ALLOC: state_d = S_ALLOC;
						FUNC_FREE:  state_d = S_FREE;
						default:    state_d = S_NOP;
					endcase
				end
			end
			S_ADD1:   state_d = S_ADD2;
			S_ADD2:   state_d = S_ADD3;
			S_ADD3:   state_d = S_ADD4;
			S_ALLOC: begin
				if (stack_count_q != '0) begin
					state_d = S_POP_WB;
				end else if (cursor_q < region_count_q) begin
					state_d = S_RGN_WB;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_RGN_WB: begin
				if (!rgn_has_page && cursor_inc < region_count_q) begin
					state_d = S_RGN_WB;
				end else begin
					state_d = S_IDLE;
				end
			end
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		fin         = 1'b0;
		fin_status  = ST_OK;
		fin_page    = '0;
		stack_we    = 1'b0;
		stack_waddr = stack_count_q[STACK_AW-1:0];
		stack_wdata = freed_q[ADDR_W-1:PAGE_SHIFT];
		stack_raddr = STACK_AW'(stack_count_q - STACK_CW'(1));
		rgn_we      = 1'b0;
		rgn_waddr   = region_count_q[RGN_AW-1:0];
		rgn_wdata   = '{next_pn: clip.start_pn, limit_pn: clip.stop_pn};
		rgn_raddr   = cursor_q[RGN_AW-1:0];
		cnt_add     = 1'b0;
		cnt_sub     = 1'b0;
		add_bytes   = clip.bytes;
		stack_inc   = 1'b0;
		stack_dec   = 1'b0;
		rgn_inc     = 1'b0;
		cur_inc     = 1'b0;
		case (state_q)
			S_ADD4: begin
				fin = 1'b1;
				if (clip.empty) begin
					fin_status = ST_EMPTY;
				end else if (region_count_q == RGN_FULL_CNT) begin
					fin_status = ST_TABLE_FULL;
				end else begin
					rgn_we  = 1'b1;
					rgn_inc = 1'b1;
					cnt_add = 1'b1;
				end
			end
			S_ALLOC: begin
				if (stack_count_q == '0 && !(cursor_q < region_count_q)) begin
					fin        = 1'b1;
					fin_status = ST_OOM;
				end
			end
			S_POP_WB: begin
				fin       = 1'b1;
				fin_page  = ADDR_W'({stack_rdata, {PAGE_SHIFT{1'b0}}});
				stack_dec = 1'b1;
				cnt_sub   = 1'b1;
			end
			S_RGN_WB: begin
				if (rgn_has_page) begin
					fin       = 1'b1;
					fin_page  = ADDR_W'({rgn_rdata.next_pn, {PAGE_SHIFT{1'b0}}});
					rgn_we    = 1'b1;
					rgn_waddr = cursor_q[RGN_AW-1:0];
					rgn_wdata = '{next_pn: rgn_rdata.next_pn + PN_W'(1),
					              limit_pn: rgn_rdata.limit_pn};
					cnt_sub   = 1'b1;
				end else begin
					cur_inc   = 1'b1;
					rgn_raddr = cursor_inc[RGN_AW-1:0];
					if (!(cursor_inc < region_count_q)) begin
						fin        = 1'b1;
						fin_status = ST_OOM;
					end
				end
			end
			S_FREE: begin
				fin = 1'b1;
				if (stack_count_q == STACK_FULL_CNT) begin
					fin_status = ST_STACK_FULL;
				end else begin
					stack_we  = 1'b1;
					stack_inc = 1'b1;
					cnt_add   = 1'b1;
					add_bytes = LEN_W'(PAGE_BYTES);
				end
			end
			S_NOP: begin
				fin = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		count_sum    = {1'b0, free_count_q} + {1'b0, add_bytes};
		free_count_d = free_count_q;
		if (cnt_add) begin
			free_count_d = count_sum[CNT_W] ? '1 : count_sum[CNT_W-1:0];
		end else if (cnt_sub) begin
			free_count_d = (free_count_q > PAGE_CNT) ? free_count_q - PAGE_CNT : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			low_floor_q    <= ADDR_W'(48'h10_0000);
			res_start_q    <= '0;
			res_end_q      <= '0;
			addr_limit_q   <= LEN_W'(1) << ADDR_W;
			stack_count_q  <= '0;
			region_count_q <= '0;
			cursor_q       <= '0;
			free_count_q   <= '0;
			done_q         <= 1'b0;
		end else begin
			state_q      <= state_d;
			done_q       <= fin;
			free_count_q <= free_count_d;
			if (stack_inc) begin
				stack_count_q <= stack_count_q + STACK_CW'(1);
			end else if (stack_dec) begin
				stack_count_q <= stack_count_q - STACK_CW'(1);
			end
			if (rgn_inc) begin
				region_count_q <= region_count_q + RGN_CW'(1);
			end
			if (cur_inc) begin
				cursor_q <= cursor_inc;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_LOW_FLOOR:      low_floor_q  <= cfg_data[ADDR_W-1:0];
					CFG_RESERVED_START: res_start_q  <= cfg_data[ADDR_W-1:0];
					CFG_RESERVED_END:   res_end_q    <= cfg_data[ADDR_W-1:0];
					CFG_ADDRESS_LIMIT:  addr_limit_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			base_q   <= region_base;
			length_q <= region_length;
			freed_q  <= freed_page;
		end
		if (fin) begin
			page_q   <= fin_page;
			status_q <= fin_status;
		end
	end

endmodule
